@@ hdl/tds_pkg.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tds_pkg
// Shared constants and types for the tridiagonal system solver.
// ---------------------------------------------------------------------------
package tds_pkg;
    localparam int MAX_ROWS_DEF  = 64;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int IDX_W         = 6;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FDIV,
        ST_FMUL_P,
        ST_FMUL_S,
        ST_FSTORE,
        ST_BREAD,
        ST_BMUL,
        ST_BDIV,
        ST_BOUT
    } t_state;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            return 32'sh80000000;
        end else begin
            return v[31:0];
        end
    endfunction
endpackage : tds_pkg
`default_nettype wire

@@ hdl/tds_if.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tds_row_if / tds_sol_if
// Valid/ready channels carrying one row word in and one solution word out.
// ---------------------------------------------------------------------------
interface tds_row_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] sub_coef;
    logic signed [31:0] diag_coef;
    logic signed [31:0] super_coef;
    logic signed [31:0] rhs_value;
    logic               last_row;
    modport source (output valid, sub_coef, diag_coef, super_coef, rhs_value, last_row,
                    input ready);
    modport sink   (input valid, sub_coef, diag_coef, super_coef, rhs_value, last_row,
                    output ready);
endinterface : tds_row_if

interface tds_sol_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] x_value;
    logic [5:0]         row_index;
    logic               last_out;
    logic               pivot_zero;
    modport source (output valid, x_value, row_index, last_out, pivot_zero, input ready);
    modport sink   (input valid, x_value, row_index, last_out, pivot_zero, output ready);
endinterface : tds_sol_if
`default_nettype wire

@@ hdl/tridiagonal_system_solver.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tridiagonal_system_solver
// Thomas algorithm over Q(32-F).F rows, one shared divider and one multiplier.
// ---------------------------------------------------------------------------
// Forward row: one divide and two multiplies, none for the first row. The last
// row, or the row that fills the store, starts back-substitution: one multiply
// and one divide per solution word, issued from index n-1 down to 0.
// One row at a time; not ready while a row or the result sweep is in work.
// Synchronous active-low reset clears control; row stores are unset until written.
module tridiagonal_system_solver
    import tds_pkg::*;
#(
    parameter int MAX_ROWS  = MAX_ROWS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tds_row_if.sink    i_row,
    tds_sol_if.source  o_sol
);
    localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    logic signed [31:0] r_piv [MAX_ROWS];
    logic signed [31:0] r_up  [MAX_ROWS];
    logic signed [31:0] r_side[MAX_ROWS];

    t_state r_state, n_state;
    logic [AW-1:0]      r_idx;     // current row
    logic [AW-1:0]      r_k;       // back-sub index
    logic [AW-1:0]      r_rd_a;
    logic               r_zero;
    logic               r_end;
    logic signed [31:0] r_a, r_b, r_c, r_d;
    logic signed [31:0] r_pp, r_pc, r_ps;   // previous row values, later the back-sub row (registered read)
    logic signed [31:0] r_w, r_p, r_x;
    logic signed [31:0] r_m2;
    logic               r_first;
    logic               r_ov;
    logic signed [31:0] r_outx;
    logic [5:0]         r_outi;
    logic               r_outl, r_outz;

    logic               w_dstart;
    logic signed [31:0] w_dnum, w_dden;
    logic               w_ddone;
    logic signed [31:0] w_dq;
    logic signed [63:0] w_prod;
    logic signed [65:0] w_rnd;
    logic signed [31:0] w_mq;
    logic               w_acc;

    tds_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_num(w_dnum), .i_den(w_dden), .o_done(w_ddone), .o_quo(w_dq)
    );

    assign w_acc = i_row.valid && i_row.ready;

    // shared multiplier, operands picked by state
    always_comb begin
        case (r_state)
            ST_FMUL_P: w_prod = r_w * r_pc;
            ST_FMUL_S: w_prod = r_w * r_ps;
            default:   w_prod = r_pc * r_x;
        endcase
        w_rnd = (66'(w_prod) + (66'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        w_mq  = sat32(w_rnd);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (w_acc) n_state = ST_FDIV;
            ST_FDIV:   if (r_first || w_ddone) n_state = r_first ? ST_FSTORE : ST_FMUL_P;
            ST_FMUL_P: n_state = ST_FMUL_S;
            ST_FMUL_S: n_state = ST_FSTORE;
            ST_FSTORE: n_state = r_end ? ST_BREAD : ST_IDLE;
            ST_BREAD:  n_state = ST_BMUL;
            ST_BMUL:   n_state = ST_BDIV;
            ST_BDIV:   if (w_ddone) n_state = ST_BOUT;
            ST_BOUT:   if (!o_sol.valid) n_state = (r_k == '0) ? ST_IDLE : ST_BREAD;
            default:   n_state = ST_IDLE;
        endcase
    end

    // divider issue: forward at entry to FDIV, back-sub at end of BMUL
    always_comb begin
        w_dstart = 1'b0;
        w_dnum   = r_a;
        w_dden   = r_pp;
        case (r_state)
            ST_IDLE: w_dstart = 1'b0;
            ST_BMUL: begin
                w_dstart = 1'b1;
                w_dnum   = r_first ? r_ps :
                           sat32(66'(r_ps) - 66'(w_mq));
                w_dden   = r_pp;
            end
            default: w_dstart = 1'b0;
        endcase
        if (r_state == ST_FDIV && !r_first && !r_ov) w_dstart = 1'b1;
    end

    assign i_row.ready = (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_zero      <= 1'b0;
            r_ov        <= 1'b0;
            o_sol.valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_sol.valid && o_sol.ready) o_sol.valid <= 1'b0;
            case (r_state)
                ST_IDLE: r_ov <= 1'b0;
                ST_FDIV: r_ov <= 1'b1;
                ST_FSTORE: begin
                    if (r_p == 0) r_zero <= 1'b1;
                    r_ov <= 1'b0;
                    if (!r_end) r_idx <= r_idx + 1'b1;
                end
                ST_BDIV: if (w_ddone) begin
                    o_sol.valid <= 1'b1;
                end
                ST_BOUT: if (!o_sol.valid && r_k == '0) begin
                    r_idx  <= '0;
                    r_zero <= 1'b0;
                end
                default: r_ov <= r_ov;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: if (w_acc) begin
                r_a     <= i_row.sub_coef;
                r_b     <= i_row.diag_coef;
                r_c     <= i_row.super_coef;
                r_d     <= i_row.rhs_value;
                r_end   <= i_row.last_row || (32'(r_idx) == 32'(MAX_ROWS - 1));
                r_first <= (r_idx == '0);
                r_pp    <= r_piv [r_idx - 1'b1];
                r_pc    <= r_up  [r_idx - 1'b1];
                r_ps    <= r_side[r_idx - 1'b1];
            end
            ST_FDIV: if (r_first) begin
                r_p <= r_b;
                r_m2 <= r_d;
            end else if (w_ddone) begin
                r_w <= w_dq;
            end
            ST_FMUL_P: r_p  <= sat32(66'(r_b) - 66'(w_mq));
            ST_FMUL_S: r_m2 <= sat32(66'(r_d) - 66'(w_mq));
            ST_FSTORE: begin
                r_piv [r_idx] <= r_p;
                r_side[r_idx] <= r_m2;
                r_up  [r_idx] <= r_c;
                r_k    <= r_idx;
                r_rd_a <= r_idx;
                r_first <= 1'b1;
            end
            ST_BREAD: begin
                r_pp <= r_piv [r_rd_a];
                r_pc <= r_up  [r_rd_a];
                r_ps <= r_side[r_rd_a];
            end
            ST_BDIV: if (w_ddone) begin
                r_x    <= w_dq;
                r_outx <= w_dq;
                r_outi <= 6'(r_k);
                r_outl <= (r_k == '0);
                r_outz <= r_zero;
            end
            ST_BOUT: if (!o_sol.valid) begin
                r_first <= 1'b0;
                r_k     <= r_k - 1'b1;
                r_rd_a  <= r_k - 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_sol.x_value    = r_outx;
    assign o_sol.row_index  = r_outi;
    assign o_sol.last_out   = r_outl;
    assign o_sol.pivot_zero = r_outz;
endmodule : tridiagonal_system_solver
`default_nettype wire

@@ hdl/tds_div.sv @@
`default_nettype none
// ---------------------------------------------------------------------------
// tds_div
// Iterative fixed-point divider: sat((num << FRAC_BITS) / den), truncated.
// One quotient bit per cycle on magnitudes; x/0 saturates by sign, 0/0 is 0.
// ---------------------------------------------------------------------------
module tds_div
    import tds_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [31:0] i_num,
    input  wire logic signed [31:0] i_den,
    output logic                    o_done,
    output logic signed [31:0]      o_quo
);
    localparam int NW = 32 + FRAC_BITS;   // dividend magnitude width
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_dvd, n_dvd;   // shifts out dividend, shifts in quotient
    logic [32:0]   r_rem, n_rem;
    logic [31:0]   r_dsr;
    logic          r_neg;
    logic          r_zero;
    logic [1:0]    r_zsign;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [33:0]   w_trial;
    logic [NW:0]   w_sq;

    always_comb begin
        w_trial = {r_rem[32:0], r_dvd[NW-1]} - {2'b00, r_dsr};
        if (!w_trial[33]) begin
            n_rem = w_trial[32:0];
            n_dvd = {r_dvd[NW-2:0], 1'b1};
        end else begin
            n_rem = {r_rem[31:0], r_dvd[NW-1]};
            n_dvd = {r_dvd[NW-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy  <= (i_den != 0);
                o_done  <= (i_den == 0);
                r_cnt   <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd  <= {(i_num[31] ? 32'(-i_num) : 32'(i_num)), {FRAC_BITS{1'b0}}};
            r_rem  <= '0;
            r_dsr  <= i_den[31] ? 32'(-i_den) : 32'(i_den);
            r_neg  <= i_num[31] ^ i_den[31];
            r_zero <= (i_den == 0);
            r_zsign <= {i_num[31], i_num != 0};
        end else if (r_busy) begin
            r_dvd <= n_dvd;
            r_rem <= n_rem;
        end
    end

    always_comb begin
        w_sq = r_neg ? (NW+1)'(-{1'b0, r_dvd}) : {1'b0, r_dvd};
        if (r_zero) begin
            if (!r_zsign[0])     o_quo = '0;
            else if (r_zsign[1]) o_quo = 32'sh80000000;
            else                 o_quo = 32'sh7fffffff;
        end else if (!r_neg && (r_dvd > (NW)'(32'h7fffffff))) begin
            o_quo = 32'sh7fffffff;
        end else if (r_neg && (r_dvd > (NW)'(33'h80000000))) begin
            o_quo = 32'sh80000000;
        end else begin
            o_quo = w_sq[31:0];
        end
    end
endmodule : tds_div
`default_nettype wire

@@ tb/tb_tridiagonal_system_solver.sv @@
// ---------------------------------------------------------------------------
// tb_tridiagonal_system_solver
// Drives rows of tridiagonal systems into the solver, predicts each solution
// word with a fixed-point Thomas model and checks the words in arrival order.
// ---------------------------------------------------------------------------
module tb_tridiagonal_system_solver
    import tds_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCH_LIMIT = 200000;

    typedef struct packed {
        logic signed [31:0] x_value;
        logic [5:0]         row_index;
        logic               last_out;
        logic               pivot_zero;
    } t_solution;

    logic i_clk;
    logic i_rst_n;

    tds_row_if row_ch ();
    tds_sol_if sol_ch ();

    tridiagonal_system_solver i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_row  (row_ch.sink),
        .o_sol  (sol_ch.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // predictor state
    logic signed [31:0] pivot_q [64];
    logic signed [31:0] upper_q [64];
    logic signed [31:0] side_q  [64];
    int                 row_count;
    logic               zero_pivot_seen;
    logic signed [31:0] last_solution;
    t_solution          solution_queue [$];

    int  error_count;
    bit  quiet_mode;      // no idling on either side
    bit  hold_sink;       // long receiver hold-off
    int  idle_cycles;

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // round to nearest, ties toward +inf, via floor shift
    function automatic logic signed [31:0] fx_mul(input longint x, input longint y);
        longint p;
        p = x * y + 64'sd32768;
        return clamp32(p >>> 16);
    endfunction

    function automatic logic signed [31:0] fx_div(input longint num, input longint den);
        if (den == 0) begin
            if (num > 0) return 32'sh7fffffff;
            if (num < 0) return 32'sh80000000;
            return 32'sd0;
        end
        return clamp32((num * 64'sd65536) / den);
    endfunction

    task automatic predict_row(input logic signed [31:0] a, b, c, d, input logic last);
        int i;
        longint w;
        longint num;
        t_solution s;
        i = row_count;
        if (i == 0) begin
            pivot_q[0] = b;
            side_q[0]  = d;
        end else begin
            w = fx_div(a, pivot_q[i-1]);
            pivot_q[i] = clamp32(longint'(b) - fx_mul(w, upper_q[i-1]));
            side_q[i]  = clamp32(longint'(d) - fx_mul(w, side_q[i-1]));
        end
        upper_q[i] = c;
        if (pivot_q[i] == 0) zero_pivot_seen = 1'b1;
        row_count = i + 1;
        if (!last && row_count < 64) return;
        for (int k = row_count - 1; k >= 0; k--) begin
            num = side_q[k];
            if (k != row_count - 1)
                num = clamp32(num - fx_mul(upper_q[k], last_solution));
            last_solution = fx_div(num, pivot_q[k]);
            s.x_value = last_solution;
            s.row_index = k[5:0];
            s.last_out = (k == 0);
            s.pivot_zero = zero_pivot_seen;
            solution_queue.push_back(s);
        end
        row_count = 0;
        zero_pivot_seen = 1'b0;
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        error_count++;
        $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    // sender idles in bursts; valid stays up after a word until the next call
    task automatic send_row(input logic signed [31:0] a, b, c, d, input logic last);
        if (!quiet_mode && $urandom_range(0, 3) == 0) begin
            row_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        row_ch.valid      <= 1'b1;
        row_ch.sub_coef   <= a;
        row_ch.diag_coef  <= b;
        row_ch.super_coef <= c;
        row_ch.rhs_value  <= d;
        row_ch.last_row   <= last;
        @(posedge i_clk);
        while (!row_ch.ready) @(posedge i_clk);
        predict_row(a, b, c, d, last);
    endtask

    // diagonally dominant rows give meaningful solutions
    task automatic send_system(input int n);
        logic signed [31:0] a, b, c, d;
        for (int r = 0; r < n; r++) begin
            a = $urandom_range(0, 65535 * 2) - 65535;
            c = $urandom_range(0, 65535 * 2) - 65535;
            b = $urandom_range(3 * 65536, 8 * 65536);
            if ($urandom_range(0, 1)) b = -b;
            d = $urandom;
            d = d >>> $urandom_range(4, 14);
            send_row(a, b, c, d, r == n - 1);
        end
    endtask

    task automatic test_directed();
        send_row(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1'b1);
        send_row(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000, 1'b1);
        // zero pivot at first row, dividend signs
        send_row(0, 0, 32'sh10000, 32'sh10000, 1'b0);
        send_row(32'sh10000, 32'sh20000, 0, -32'sh10000, 1'b1);
        send_row(0, 0, 0, 0, 1'b1);
        // zero pivot created by elimination
        send_row(0, 32'sh10000, 32'sh10000, 32'sh30000, 1'b0);
        send_row(32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000, 1'b0);
        send_row(32'sh10000, 32'sh20000, 0, 32'sh8000, 1'b1);
        send_row(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff, 1'b1);
        send_row(32'h55555555, 32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 1'b0);
        send_row(32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa, 32'h55555555, 1'b1);
        send_row(1, 1, 1, 1, 1'b1);
        send_system(5);
    endtask

    task automatic wait_drained();
        row_ch.valid <= 1'b0;
        while (solution_queue.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    // full store ends the run with no last marker
    task automatic test_full_store();
        for (int r = 0; r < 64; r++)
            send_row($urandom_range(0, 65535), $urandom_range(4 * 65536, 6 * 65536),
                     $urandom_range(0, 65535), $urandom, 1'b0);
    endtask

    // sender keeps offering the next system while the receiver holds off
    task automatic test_backpressure();
        hold_sink = 1'b1;
        fork
            begin
                repeat (3000) @(posedge i_clk);
                hold_sink = 1'b0;
            end
            begin
                send_system(3);
                send_system(2);
            end
        join
    endtask

    task automatic test_random(input int rows);
        int sent;
        int n;
        sent = 0;
        while (sent < rows) begin
            if ($urandom_range(0, 4) == 0) begin
                // raw noise
                send_row($urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1));
                sent++;
            end else begin
                n = $urandom_range(1, 8);
                send_system(n);
                sent += n;
            end
        end
        // finish any open system from noise rows
        send_system(1);
    endtask

    // sink side
    initial begin
        sol_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_sink) begin
                sol_ch.ready <= 1'b0;
                @(posedge i_clk);
            end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
                sol_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                sol_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // compare each solution word
    always @(posedge i_clk) begin
        t_solution w;
        if (i_rst_n && sol_ch.valid && sol_ch.ready) begin
            if (solution_queue.size() == 0) begin
                report_mismatch("unexpected word, index", sol_ch.row_index, -1);
            end else begin
                w = solution_queue.pop_front();
                if (sol_ch.x_value !== w.x_value)
                    report_mismatch("x_value", sol_ch.x_value, w.x_value);
                if (sol_ch.row_index !== w.row_index)
                    report_mismatch("row_index", sol_ch.row_index, w.row_index);
                if (sol_ch.last_out !== w.last_out)
                    report_mismatch("last_out", sol_ch.last_out, w.last_out);
                if (sol_ch.pivot_zero !== w.pivot_zero)
                    report_mismatch("pivot_zero", sol_ch.pivot_zero, w.pivot_zero);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((row_ch.valid && row_ch.ready) || (sol_ch.valid && sol_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        error_count = 0;
        idle_cycles = 0;
        quiet_mode = 1'b0;
        hold_sink = 1'b0;
        row_count = 0;
        zero_pivot_seen = 1'b0;
        last_solution = 0;
        i_rst_n <= 1'b0;
        row_ch.valid <= 1'b0;
        row_ch.sub_coef <= '0;
        row_ch.diag_coef <= '0;
        row_ch.super_coef <= '0;
        row_ch.rhs_value <= '0;
        row_ch.last_row <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_store();
        test_backpressure();
        test_random(40);
        quiet_mode = 1'b1;
        test_random(18);
        wait_drained();
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
